>>> hw/rtl/sle_pkg.sv
// shared types and constants for the sequential list engine
`default_nettype none

package sle_pkg;

    // field widths fixed by the request and result formats
    localparam int POS_W         = 9;
    localparam int KEY_W         = 32;
    localparam int VAL_W         = 32;
    localparam int DEFAULT_DEPTH = 256;

    // stream widths, padded to whole bytes
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 88;

    // request codes as they arrive on the input stream
    typedef enum logic [1:0] {
        REQ_GET    = 2'd0,
        REQ_LOCATE = 2'd1,
        REQ_INSERT = 2'd2,
        REQ_DELETE = 2'd3
    } req_t;

    // per-cycle command broadcast to every cell
    typedef enum logic [1:0] {
        CMD_HOLD   = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_DELETE = 2'd2
    } cmd_op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } rec_t;

    // shift command: p0 is the zero-based position
    typedef struct packed {
        cmd_op_t          op;
        logic [POS_W-1:0] p0;
        rec_t             rec;
    } cmd_t;

    // read wavefront travelling down the chain one cell per cycle
    typedef struct packed {
        logic             valid;
        logic             is_get;
        logic [POS_W-1:0] target;
        logic [KEY_W-1:0] key;
        logic             hit;
        logic [POS_W-1:0] found;
        rec_t             data;
    } wave_t;

endpackage

`default_nettype wire

>>> hw/rtl/sle_cell.sv
// one list cell: holds a record, shifts with its neighbors, serves the read wave
`default_nettype none

module sle_cell #(
    parameter int INDEX = 0,
    parameter int XW    = 10
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire sle_pkg::cmd_t   cmd,
    input  wire logic [XW-1:0]   fill_count,
    input  wire sle_pkg::rec_t   left_rec,
    input  wire sle_pkg::rec_t   right_rec,
    output sle_pkg::rec_t        rec,
    input  wire sle_pkg::wave_t  wave_in,
    output sle_pkg::wave_t       wave_out
);

    localparam logic [XW-1:0]             IDX   = XW'(INDEX);
    localparam logic [sle_pkg::POS_W-1:0] FOUND = sle_pkg::POS_W'(INDEX + 1);

    sle_pkg::rec_t  rec_reg;
    sle_pkg::rec_t  rec_next;
    sle_pkg::wave_t wave_reg;
    sle_pkg::wave_t wave_next;

    logic [XW-1:0] p0_x;
    logic [XW-1:0] target_x;

    assign p0_x     = XW'(cmd.p0);
    assign target_x = XW'(wave_in.target);

    // shift up on insert, down on delete
    always_comb begin
        rec_next = rec_reg;
        case (cmd.op)
            sle_pkg::CMD_INSERT: begin
                if (IDX > p0_x) begin
                    rec_next = left_rec;
                end else if (IDX == p0_x) begin
                    rec_next = cmd.rec;
                end
            end
            sle_pkg::CMD_DELETE: begin
                if (IDX >= p0_x) begin
                    rec_next = right_rec;
                end
            end
            default: begin
                rec_next = rec_reg;
            end
        endcase
    end

    // read wave: pick up the record for get, first key match for locate
    always_comb begin
        wave_next = wave_in;
        if (wave_in.valid) begin
            if (wave_in.is_get) begin
                if (IDX == target_x) begin
                    wave_next.data = rec_reg;
                end
            end else if (!wave_in.hit && (IDX < fill_count) && (rec_reg.key == wave_in.key)) begin
                wave_next.hit   = 1'b1;
                wave_next.found = FOUND;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rec_reg <= rec_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wave_reg.valid <= 1'b0;
        end else begin
            wave_reg <= wave_next;
        end
    end

    assign rec      = rec_reg;
    assign wave_out = wave_reg;

endmodule

`default_nettype wire

>>> hw/rtl/sequential_list_engine.sv
// top level of the sequential list engine: request decode, cell chain and result register
`default_nettype none

// Ordered list of up to DEPTH key/value records held in a row of cells, one record per
// cell. Insert and delete shift every cell at once, so they (and any request rejected
// for a bad position or a full list) give their result in the cycle after the request
// transaction. Get and locate send a read wave down the chain that visits one cell per
// cycle; their result passes from the launch register through the wave register of
// every cell into the result register. One request is in flight at a time. No clearing
// pass is needed after reset: only positions below the fill count are ever read.
module sequential_list_engine #(
    parameter int DEPTH = sle_pkg::DEFAULT_DEPTH
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // req_type[1:0], position[10:2], entry_key[42:11], entry_value[74:43], zero pad
    input  wire logic [sle_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // status[0], found_position[9:1], out_key[41:10], out_value[73:42], count[82:74]
    output logic [sle_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int XW = ((CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W) + 1;

    sle_pkg::state_t state_reg;
    sle_pkg::state_t state_next;
    logic [CW-1:0]   fill_reg;
    logic [CW-1:0]   fill_next;
    sle_pkg::wave_t  launch_reg;
    sle_pkg::wave_t  launch_next;
    logic            m_valid_reg;
    logic            m_valid_next;
    logic [sle_pkg::M_TDATA_W-1:0] m_data_reg;
    logic [sle_pkg::M_TDATA_W-1:0] m_data_next;

    sle_pkg::cmd_t   cmd;
    sle_pkg::rec_t   rec_w  [DEPTH];
    sle_pkg::wave_t  wave_w [DEPTH+1];
    sle_pkg::wave_t  wave_exit;

    sle_pkg::req_t                 req;
    logic [sle_pkg::POS_W-1:0]     pos;
    logic [sle_pkg::KEY_W-1:0]     key;
    logic [sle_pkg::VAL_W-1:0]     val;
    logic [XW-1:0]                 pos_x;
    logic [XW-1:0]                 fill_x;
    logic [XW-1:0]                 fill_next_x;
    logic                          rd_ok;
    logic                          ins_ok;
    logic                          accept;
    logic                          out_load;
    logic                          out_status;
    logic [sle_pkg::POS_W-1:0]     out_found;
    sle_pkg::rec_t                 out_rec;
    logic [sle_pkg::POS_W-1:0]     out_count;

    // unpack the request transaction
    assign req    = sle_pkg::req_t'(s_tdata[1:0]);
    assign pos    = s_tdata[10:2];
    assign key    = s_tdata[42:11];
    assign val    = s_tdata[74:43];
    assign pos_x  = XW'(pos);
    assign fill_x = XW'(fill_reg);

    // position checks
    assign rd_ok  = (pos != '0) && (pos_x <= fill_x);
    assign ins_ok = (pos != '0) && (pos_x <= fill_x + XW'(1)) && (fill_x < XW'(DEPTH));

    assign s_tready  = (state_reg == sle_pkg::ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept    = s_tvalid && s_tready;
    assign wave_exit = wave_w[DEPTH];

    // request decode, fill count, wave launch and result formatting
    always_comb begin
        state_next         = state_reg;
        fill_next          = fill_reg;
        launch_next        = launch_reg;
        launch_next.valid  = 1'b0;
        cmd.op             = sle_pkg::CMD_HOLD;
        cmd.p0             = pos - sle_pkg::POS_W'(1);
        cmd.rec.key        = key;
        cmd.rec.value      = val;
        out_load           = 1'b0;
        out_status         = 1'b0;
        out_found          = '0;
        out_rec            = '0;
        fill_next_x        = '0;
        case (state_reg)
            sle_pkg::ST_IDLE: begin
                if (accept) begin
                    case (req)
                        sle_pkg::REQ_GET: begin
                            if (rd_ok) begin
                                state_next = sle_pkg::ST_SCAN;
                                launch_next.valid = 1'b1;
                            end else begin
                                out_load   = 1'b1;
                                out_status = 1'b1;
                            end
                        end
                        sle_pkg::REQ_LOCATE: begin
                            state_next = sle_pkg::ST_SCAN;
                            launch_next.valid = 1'b1;
                        end
                        sle_pkg::REQ_INSERT: begin
                            out_load = 1'b1;
                            if (ins_ok) begin
                                cmd.op    = sle_pkg::CMD_INSERT;
                                fill_next = fill_reg + CW'(1);
                            end else begin
                                out_status = 1'b1;
                            end
                        end
                        sle_pkg::REQ_DELETE: begin
                            out_load = 1'b1;
                            if (rd_ok) begin
                                cmd.op    = sle_pkg::CMD_DELETE;
                                fill_next = fill_reg - CW'(1);
                            end else begin
                                out_status = 1'b1;
                            end
                        end
                        default: begin
                            out_load = 1'b0;
                        end
                    endcase
                    launch_next.is_get = (req == sle_pkg::REQ_GET);
                    launch_next.target = pos - sle_pkg::POS_W'(1);
                    launch_next.key    = key;
                    launch_next.hit    = 1'b0;
                    launch_next.found  = '0;
                    launch_next.data   = '0;
                end
            end
            sle_pkg::ST_SCAN: begin
                if (wave_exit.valid) begin
                    state_next = sle_pkg::ST_IDLE;
                    out_load   = 1'b1;
                    if (wave_exit.is_get) begin
                        out_rec = wave_exit.data;
                    end else if (wave_exit.hit) begin
                        out_found = wave_exit.found;
                    end
                end
            end
            default: begin
                state_next = sle_pkg::ST_IDLE;
            end
        endcase
        fill_next_x = XW'(fill_next);
        out_count   = fill_next_x[sle_pkg::POS_W-1:0];
    end

    // result register
    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (out_load) begin
            m_valid_next = 1'b1;
            m_data_next  = {5'b0, out_count, out_rec.value, out_rec.key, out_found, out_status};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= sle_pkg::ST_IDLE;
            fill_reg         <= '0;
            launch_reg.valid <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            launch_reg  <= launch_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tdata  = m_data_reg;
    assign m_tvalid = m_valid_reg;

    // chain of cells
    assign wave_w[0] = launch_reg;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        sle_pkg::rec_t left_w;
        sle_pkg::rec_t right_w;

        if (i == 0) begin : g_first
            assign left_w = rec_w[i];
        end else begin : g_inner_l
            assign left_w = rec_w[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = rec_w[i];
        end else begin : g_inner_r
            assign right_w = rec_w[i+1];
        end

        sle_cell #(
            .INDEX (i),
            .XW    (XW)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .fill_count (fill_x),
            .left_rec   (left_w),
            .right_rec  (right_w),
            .rec        (rec_w[i]),
            .wave_in    (wave_w[i]),
            .wave_out   (wave_w[i+1])
        );
    end

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// self-checking testbench for the sequential list engine
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH     = sle_pkg::DEFAULT_DEPTH;
    localparam int LONG_HOLD = 400;
    localparam int POOL_N    = 12;

    // one request as the generator builds it
    typedef struct {
        sle_pkg::req_t                 op;
        logic [sle_pkg::POS_W-1:0]     pos;
        logic [sle_pkg::KEY_W-1:0]     key;
        logic [sle_pkg::VAL_W-1:0]     value;
    } list_req_t;

    // one result as the engine returns it
    typedef struct {
        logic                          status;
        logic [sle_pkg::POS_W-1:0]     found;
        logic [sle_pkg::KEY_W-1:0]     key;
        logic [sle_pkg::VAL_W-1:0]     value;
        logic [sle_pkg::POS_W-1:0]     fill;
    } list_result_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic [sle_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [sle_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;

    // requests waiting to be driven and results waiting to arrive
    list_req_t    req_queue[$];
    list_result_t pending_results[$];

    // predicted contents of the list
    sle_pkg::rec_t shadow_list [DEPTH];
    int            shadow_fill = 0;

    // fill level as the generator sees it, ahead of the engine
    int gen_fill     = 0;
    int issued_cnt   = 0;
    int accepted_cnt = 0;
    int mismatches   = 0;

    int phase          = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    bit long_hold_done = 1'b0;
    bit req_taken      = 1'b0;

    logic [sle_pkg::KEY_W-1:0] key_pool [POOL_N] = '{
        32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
        32'h7FFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0000_FFFF,
        32'hFFFF_0000, 32'h1234_5678, 32'hDEAD_BEEF, 32'h0F0F_0F0F
    };

    sequential_list_engine #(.DEPTH(DEPTH)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always #1 aclk = ~aclk;

    // apply one request to the shadow list and work out its result
    task automatic list_apply(input list_req_t rq, output list_result_t res);
        int k;
        int p;
        p = int'(rq.pos);
        res = '{status: 1'b0, found: '0, key: '0, value: '0, fill: '0};
        case (rq.op)
            sle_pkg::REQ_GET: begin
                if (p < 1 || p > shadow_fill) begin
                    res.status = 1'b1;
                end else begin
                    res.key   = shadow_list[p-1].key;
                    res.value = shadow_list[p-1].value;
                end
            end
            sle_pkg::REQ_LOCATE: begin
                for (k = 0; k < shadow_fill; k++) begin
                    if (shadow_list[k].key == rq.key) begin
                        res.found = sle_pkg::POS_W'(k + 1);
                        break;
                    end
                end
            end
            sle_pkg::REQ_INSERT: begin
                if (p < 1 || p > shadow_fill + 1 || shadow_fill >= DEPTH) begin
                    res.status = 1'b1;
                end else begin
                    for (k = shadow_fill; k >= p; k--)
                        shadow_list[k] = shadow_list[k-1];
                    shadow_list[p-1].key   = rq.key;
                    shadow_list[p-1].value = rq.value;
                    shadow_fill++;
                end
            end
            default: begin
                if (p < 1 || p > shadow_fill) begin
                    res.status = 1'b1;
                end else begin
                    for (k = p - 1; k + 1 < shadow_fill; k++)
                        shadow_list[k] = shadow_list[k+1];
                    shadow_fill--;
                end
            end
        endcase
        res.fill = sle_pkg::POS_W'(shadow_fill);
    endtask

    // queue a request and keep the generator's view of the fill level
    task automatic push_req(input sle_pkg::req_t op, input int pos,
                            input logic [sle_pkg::KEY_W-1:0] key,
                            input logic [sle_pkg::VAL_W-1:0] value);
        list_req_t rq;
        rq.op    = op;
        rq.pos   = sle_pkg::POS_W'(pos);
        rq.key   = key;
        rq.value = value;
        case (op)
            sle_pkg::REQ_INSERT:
                if (pos >= 1 && pos <= gen_fill + 1 && gen_fill < DEPTH) gen_fill++;
            sle_pkg::REQ_DELETE:
                if (pos >= 1 && pos <= gen_fill) gen_fill--;
            default: ;
        endcase
        req_queue.push_back(rq);
        issued_cnt++;
    endtask

    // keys mostly from a small pool so that locate hits and duplicates happen
    function automatic logic [sle_pkg::KEY_W-1:0] pool_key();
        if ($urandom_range(0, 3) != 0)
            return key_pool[$urandom_range(0, POOL_N - 1)];
        return $urandom();
    endfunction

    // mostly well-formed requests, some noise
    task automatic mix_item();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            push_req(sle_pkg::REQ_INSERT, $urandom_range(1, gen_fill + 1), pool_key(),
                     $urandom());
        else if (r < 50 && gen_fill > 0)
            push_req(sle_pkg::REQ_DELETE, $urandom_range(1, gen_fill), '0, $urandom());
        else if (r < 65 && gen_fill > 0)
            push_req(sle_pkg::REQ_GET, $urandom_range(1, gen_fill), $urandom(), $urandom());
        else if (r < 80)
            push_req(sle_pkg::REQ_LOCATE, $urandom_range(0, 511), pool_key(), $urandom());
        else
            push_req(sle_pkg::req_t'(2'($urandom_range(0, 3))), $urandom_range(0, 511),
                     $urandom(), $urandom());
    endtask

    // hold off until every request is taken and every result is back
    task automatic wait_drained();
        do @(negedge aclk);
        while (accepted_cnt != issued_cnt || pending_results.size() != 0);
    endtask

    function automatic void check_field(input string name, input logic [31:0] exp_v,
                                        input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    // request driver: new transaction only after the current one is taken
    always @(negedge aclk) begin : drive_requests
        list_req_t rq;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || req_taken) begin
            req_taken = 1'b0;
            if (req_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                rq = req_queue.pop_front();
                s_tdata  <= {5'b0, rq.value, rq.key, rq.pos, rq.op};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result ready: one long hold-off, then random stalls
    always @(negedge aclk) begin : drive_ready
        if (phase == 1 && !long_hold_done) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // check each result transaction, then predict each request transaction
    always @(posedge aclk) begin : monitor
        list_req_t    rq;
        list_result_t got;
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.status = m_tdata[0];
            got.found  = m_tdata[9:1];
            got.key    = m_tdata[41:10];
            got.value  = m_tdata[73:42];
            got.fill   = m_tdata[82:74];
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none actual %h",
                         $realtime, m_tdata);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(got.status));
                check_field("found_position", 32'(want.found), 32'(got.found));
                check_field("out_key", want.key, got.key);
                check_field("out_value", want.value, got.value);
                check_field("count", 32'(want.fill), 32'(got.fill));
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            rq.op    = sle_pkg::req_t'(s_tdata[1:0]);
            rq.pos   = s_tdata[10:2];
            rq.key   = s_tdata[42:11];
            rq.value = s_tdata[74:43];
            list_apply(rq, want);
            pending_results.push_back(want);
            accepted_cnt++;
            req_taken = 1'b1;
        end
    end

    // stimulus in phases, each with its own idling pattern
    initial begin : stimulus
        aresetn <= 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty list, bad positions, edges of the list, duplicate keys
        push_req(sle_pkg::REQ_GET, 1, '0, '0);
        push_req(sle_pkg::REQ_LOCATE, 0, '0, '0);
        push_req(sle_pkg::REQ_DELETE, 1, '0, '0);
        push_req(sle_pkg::REQ_INSERT, 0, 32'h1111_1111, 32'h2222_2222);
        push_req(sle_pkg::REQ_INSERT, 2, 32'h1111_1111, 32'h2222_2222);
        push_req(sle_pkg::REQ_INSERT, 1, 32'h0000_0000, 32'h0000_0000);
        push_req(sle_pkg::REQ_INSERT, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(sle_pkg::REQ_INSERT, 3, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
        push_req(sle_pkg::REQ_INSERT, 2, 32'h0000_0000, 32'h1234_5678);
        push_req(sle_pkg::REQ_GET, 1, '0, '0);
        push_req(sle_pkg::REQ_GET, 4, '0, '0);
        push_req(sle_pkg::REQ_GET, 5, '0, '0);
        push_req(sle_pkg::REQ_GET, 0, '0, '0);
        push_req(sle_pkg::REQ_GET, 511, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_req(sle_pkg::REQ_LOCATE, 0, 32'h0000_0000, '0);
        push_req(sle_pkg::REQ_LOCATE, 0, 32'hFFFF_FFFF, '0);
        push_req(sle_pkg::REQ_LOCATE, 511, 32'h1357_9BDF, '0);
        push_req(sle_pkg::REQ_INSERT, 511, 32'h1111_1111, 32'h2222_2222);
        push_req(sle_pkg::REQ_DELETE, 0, '0, '0);
        push_req(sle_pkg::REQ_DELETE, 5, '0, '0);
        push_req(sle_pkg::REQ_DELETE, 2, '0, '0);
        push_req(sle_pkg::REQ_DELETE, 3, '0, '0);
        push_req(sle_pkg::REQ_DELETE, 1, '0, '0);
        push_req(sle_pkg::REQ_GET, 1, '0, '0);
        push_req(sle_pkg::REQ_DELETE, 1, '0, '0);
        wait_drained();

        // random mix, receiver holds off long at the start
        phase = 1;
        repeat (60) mix_item();
        wait_drained();

        // fill the list to the top with a slow sender, then hit the full case
        phase         = 2;
        send_idle_pct = 78;
        while (gen_fill < DEPTH) begin
            if ($urandom_range(0, 99) < 94)
                push_req(sle_pkg::REQ_INSERT, $urandom_range(1, gen_fill + 1), pool_key(),
                         $urandom());
            else
                mix_item();
        end
        push_req(sle_pkg::REQ_INSERT, 1, 32'h1111_1111, 32'h2222_2222);
        push_req(sle_pkg::REQ_INSERT, DEPTH + 1, 32'h1111_1111, 32'h2222_2222);
        push_req(sle_pkg::REQ_GET, DEPTH, '0, '0);
        push_req(sle_pkg::REQ_GET, DEPTH + 1, '0, '0);
        push_req(sle_pkg::REQ_DELETE, DEPTH + 1, '0, '0);
        push_req(sle_pkg::REQ_LOCATE, 0, pool_key(), '0);
        push_req(sle_pkg::REQ_LOCATE, 0, 32'h1357_9BDF, '0);
        wait_drained();

        // drain most of the list with a stalling receiver
        phase          = 3;
        send_idle_pct  = 0;
        recv_stall_pct = 78;
        while (gen_fill > 12) begin
            if ($urandom_range(0, 99) < 88)
                push_req(sle_pkg::REQ_DELETE, $urandom_range(1, gen_fill), $urandom(),
                         $urandom());
            else
                mix_item();
        end
        wait_drained();

        // random mix with both sides idling
        phase          = 4;
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        repeat (60) mix_item();
        wait_drained();

        // room for any stray result
        repeat (DEPTH + 20) @(posedge aclk);
        if (mismatches == 0)
            $display("** sequential_list_engine: PASSED **");
        else
            $display("** sequential_list_engine: FAILED **");
        $finish;
    end

    // watchdog
    initial begin : watchdog
        #4_000_000;
        $display("** sequential_list_engine: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

>>> filelist.f
hw/rtl/sle_pkg.sv
hw/rtl/sle_cell.sv
hw/rtl/sequential_list_engine.sv
tb/sv/tb.sv
